// ===== rtl/stip_pkg.sv =====
// Package for the string to integer parser core: parse phase codes, the
// parse state and result structs, and character constants.
// No dependencies.
`default_nettype none

package stip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned END_W   = 9;

  localparam logic [MAG_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
  localparam logic [MAG_W-1:0] SAT_MAG   = 32'h8000_0000;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [2:0] {
    PH_BLANK  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
    logic             any_digit;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_RESET = '{
    phase:     PH_BLANK,
    negative:  1'b0,
    magnitude: '0,
    any_digit: 1'b0
  };

  typedef struct packed {
    logic [MAG_W-1:0] value;
    logic             range_error;
    logic [END_W-1:0] end_index;
  } parse_result_t;

endpackage

`default_nettype wire

// ===== rtl/string_to_integer_parser_core.sv =====
// String to integer parser core: strtol-style parsing of one ASCII
// character per beat, with a configurable radix.
// Depends on stip_pkg and stip_step.
//
// Characters arrive on the in_ stream, one per beat, in_tdata[7:0] = char.
// A zero byte ends the string and produces one beat on the out_ stream:
// out_tdata[31:0] is the signed value clamped to +-2147483647,
// out_tdata[40:32] the end index, and out_tuser the range error flag.
// Other characters produce no output beat.
// A character is taken into an input register, and from there the parse
// state is updated by one multiply-add of a 32 by 6 bit product; a zero
// byte in the input register writes its result into the output register.
// Throughput is one character per cycle. When the receiver stalls with a
// result waiting, non-zero characters keep flowing; only the next zero
// byte waits in the input register, and in_tready drops behind it.
// cfg_we with cfg_wdata writes the radix; write it only while idle.
// Synchronous reset clears the parse state, empties both registers and
// sets the radix to 10. No clearing pass is needed after reset.
`default_nettype none

module string_to_integer_parser_core #(
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] value, [40:32] end_index, rest zero
  output logic             out_tuser,  // [0] range_error
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata   // radix
);
  import stip_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);

  logic                 in_valid_r;
  logic [CHAR_W-1:0]    char_r;
  logic [RADIX_W-1:0]   radix_r;
  parse_state_t         state_r;
  parse_state_t         state_nxt;
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     pos_nxt;
  logic [POS_W-1:0]     stop_r;
  logic [POS_W-1:0]     stop_nxt;
  parse_result_t        result;
  logic                 out_valid_r;
  parse_result_t        out_r;
  logic                 is_end;
  logic                 fire;

  assign is_end    = (char_r == CH_NUL);
  assign fire      = in_valid_r && (!is_end || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  stip_step #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W)
  ) u_step (
    .char_in  (char_r),
    .radix    (radix_r),
    .cur      (state_r),
    .pos_cur  (pos_r),
    .stop_cur (stop_r),
    .nxt      (state_nxt),
    .pos_nxt  (pos_nxt),
    .stop_nxt (stop_nxt),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PARSE_STATE_RESET;
      pos_r   <= '0;
      stop_r  <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      stop_r  <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_end) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.end_index, out_r.value};
  assign out_tuser  = out_r.range_error;

  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_end |=> state_r == PARSE_STATE_RESET && pos_r == '0)
    else $error("parse state not cleared after a zero byte");

  a_mag_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.magnitude <= SAT_MAG)
    else $error("magnitude above saturation limit");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == LIMIT_POS ||
    out_tdata[31:0] == (MAG_W'(0) - LIMIT_POS))
    else $error("range error without a clamped value");

  a_stall_holds_char: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(char_r))
    else $error("stalled character lost from the input register");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_r))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire

// ===== rtl/stip_step.sv =====
// Next-state logic of the parser: digit decode, one multiply-add by the
// radix with saturation, phase transitions and the result on a zero byte.
// Depends on stip_pkg.
`default_nettype none

module stip_step #(
  parameter int unsigned MAX_LEN = 256,
  parameter int unsigned POS_W   = 9
) (
  input  wire logic [stip_pkg::CHAR_W-1:0]  char_in,
  input  wire logic [stip_pkg::RADIX_W-1:0] radix,
  input  wire stip_pkg::parse_state_t       cur,
  input  wire logic [POS_W-1:0]             pos_cur,
  input  wire logic [POS_W-1:0]             stop_cur,
  output stip_pkg::parse_state_t            nxt,
  output logic [POS_W-1:0]                  pos_nxt,
  output logic [POS_W-1:0]                  stop_nxt,
  output stip_pkg::parse_result_t           result
);
  import stip_pkg::*;

  localparam int unsigned PROD_W = MAG_W + RADIX_W;
  localparam int unsigned EXT_W  = POS_W + END_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  logic [DIGIT_W-1:0] digit;
  logic               is_digit;
  logic               digit_ok;
  logic               is_blank;
  logic               is_x;
  logic               hex_zero;
  logic               do_take;
  logic               base_zero;
  logic               any_before;
  logic [MAG_W-1:0]   mul_base;
  logic [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]   acc;
  logic [POS_W-1:0]   end_pos;
  logic [EXT_W-1:0]   end_ext;

  always_comb begin
    is_digit = 1'b1;
    digit    = '0;
    if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
      digit = DIGIT_W'(char_in - CH_ZERO);
    end else if (char_in >= CH_LO_A && char_in <= CH_LO_Z) begin
      digit = DIGIT_W'(char_in - CH_LO_A + 8'd10);
    end else if (char_in >= CH_UP_A && char_in <= CH_UP_Z) begin
      digit = DIGIT_W'(char_in - CH_UP_A + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign digit_ok = is_digit && (digit < radix);
  assign is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
  assign is_x     = (char_in == CH_LO_X) || (char_in == CH_UP_X);
  assign hex_zero = (radix == RADIX_HEX) && (char_in == CH_ZERO);

  // The pending zero of a hex prefix is worth 0, so its digit restarts from 0.
  assign base_zero = (cur.phase == PH_ZERO);
  assign mul_base  = base_zero ? '0 : cur.magnitude;
  assign prod      = PROD_W'(mul_base) * PROD_W'(radix) + PROD_W'(digit);
  assign acc       = (prod > PROD_W'(SAT_MAG)) ? SAT_MAG : prod[MAG_W-1:0];

  always_comb begin
    do_take    = 1'b0;
    any_before = cur.any_digit;
    nxt        = cur;
    stop_nxt   = stop_cur;
    pos_nxt    = (pos_cur < POS_MAX) ? pos_cur + POS_W'(1) : POS_MAX;

    case (cur.phase)
      PH_BLANK: begin
        if (is_blank) begin
          nxt.phase = PH_BLANK;
        end else if (char_in == CH_PLUS) begin
          nxt.phase = PH_SIGNED;
        end else if (char_in == CH_MINUS) begin
          nxt.negative = 1'b1;
          nxt.phase    = PH_SIGNED;
        end else if (hex_zero) begin
          nxt.phase = PH_ZERO;
        end else begin
          nxt.phase = PH_DIGITS;
          do_take   = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (hex_zero) begin
          nxt.phase = PH_ZERO;
        end else begin
          nxt.phase = PH_DIGITS;
          do_take   = 1'b1;
        end
      end
      PH_ZERO: begin
        nxt.phase = PH_DIGITS;
        if (!is_x) begin
          nxt.any_digit = 1'b1;
          any_before    = 1'b1;
          do_take       = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase

    if (do_take) begin
      if (digit_ok) begin
        nxt.magnitude = acc;
        nxt.any_digit = 1'b1;
      end else begin
        stop_nxt  = any_before ? pos_cur : '0;
        nxt.phase = PH_DONE;
      end
    end

    if (char_in == CH_NUL) begin
      nxt      = PARSE_STATE_RESET;
      pos_nxt  = '0;
      stop_nxt = '0;
    end
  end

  always_comb begin
    if (cur.phase == PH_DIGITS || cur.phase == PH_BLANK || cur.phase == PH_SIGNED) begin
      end_pos = cur.any_digit ? pos_cur : '0;
    end else if (cur.phase == PH_ZERO) begin
      end_pos = pos_cur;
    end else begin
      end_pos = stop_cur;
    end
    end_ext = EXT_W'(end_pos);
    result.end_index = end_ext[END_W-1:0];
    if (cur.magnitude > LIMIT_POS) begin
      result.range_error = 1'b1;
      result.value       = cur.negative ? (MAG_W'(0) - LIMIT_POS) : LIMIT_POS;
    end else begin
      result.range_error = 1'b0;
      result.value       = cur.negative ? (MAG_W'(0) - cur.magnitude) : cur.magnitude;
    end
  end

endmodule

`default_nettype wire
